@@ design/ccv_pkg.sv @@
package ccv_pkg;

    localparam int KW_COUNT = 12;
    localparam int KW_MAX_LEN = 5;

    // token roles
    localparam logic [2:0] ROLE_KEY    = 3'd0;
    localparam logic [2:0] ROLE_DISP   = 3'd1;
    localparam logic [2:0] ROLE_USER   = 3'd2;
    localparam logic [2:0] ROLE_SECRET = 3'd3;
    localparam logic [2:0] ROLE_CHAN   = 3'd4;
    localparam logic [2:0] ROLE_EXTRA  = 3'd5;

    // command kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_ERR   = 3'd1;
    localparam logic [2:0] KIND_REPLY = 3'd2;
    localparam logic [2:0] KIND_AUTH  = 3'd3;
    localparam logic [2:0] KIND_JOIN  = 3'd4;
    localparam logic [2:0] KIND_MSG   = 3'd5;
    localparam logic [2:0] KIND_BYE   = 3'd6;

    // keyword indexes
    localparam int KW_FROM  = 6;
    localparam int KW_IS    = 7;
    localparam int KW_AS    = 8;
    localparam int KW_USING = 9;
    localparam int KW_OK    = 10;
    localparam int KW_NOK   = 11;

    // register indexes
    localparam logic [1:0] REG_USER    = 2'd0;
    localparam logic [1:0] REG_DISPLAY = 2'd1;
    localparam logic [1:0] REG_SECRET  = 2'd2;
    localparam logic [1:0] REG_CONTENT = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef logic [KW_COUNT-1:0] kw_mask_t;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"E", "R", "R", 8'h00, 8'h00},
        '{"R", "E", "P", "L", "Y"},
        '{"A", "U", "T", "H", 8'h00},
        '{"J", "O", "I", "N", 8'h00},
        '{"M", "S", "G", 8'h00, 8'h00},
        '{"B", "Y", "E", 8'h00, 8'h00},
        '{"F", "R", "O", "M", 8'h00},
        '{"I", "S", 8'h00, 8'h00, 8'h00},
        '{"A", "S", 8'h00, 8'h00, 8'h00},
        '{"U", "S", "I", "N", "G"},
        '{"O", "K", 8'h00, 8'h00, 8'h00},
        '{"N", "O", "K", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd2, 3'd2, 3'd5, 3'd2, 3'd3
    };

    function automatic logic [2:0] role_of(input logic [2:0] tn, input logic [2:0] kind);
        logic [2:0] r;
        r = ROLE_EXTRA;
        if (tn == 3'd0)
        begin
            r = ROLE_KEY;
        end
        else
        begin
            unique case (kind)
                KIND_ERR, KIND_MSG:
                begin
                    if (tn == 3'd1 || tn == 3'd3)
                        r = ROLE_KEY;
                    else if (tn == 3'd2)
                        r = ROLE_DISP;
                end
                KIND_REPLY:
                begin
                    if (tn == 3'd1 || tn == 3'd2)
                        r = ROLE_KEY;
                end
                KIND_AUTH:
                begin
                    if (tn == 3'd1)
                        r = ROLE_USER;
                    else if (tn == 3'd2 || tn == 3'd4)
                        r = ROLE_KEY;
                    else if (tn == 3'd3)
                        r = ROLE_DISP;
                    else if (tn == 3'd5)
                        r = ROLE_SECRET;
                end
                KIND_JOIN:
                begin
                    if (tn == 3'd1)
                        r = ROLE_CHAN;
                    else if (tn == 3'd2)
                        r = ROLE_KEY;
                    else if (tn == 3'd3)
                        r = ROLE_DISP;
                end
                default:
                begin
                    r = ROLE_EXTRA;
                end
            endcase
        end
        return r;
    endfunction

    // keywords a token may match at its start
    function automatic kw_mask_t mask_of(input logic [2:0] tn, input logic [2:0] kind);
        kw_mask_t m;
        m = '0;
        if (tn == 3'd0)
        begin
            m = kw_mask_t'(12'h03F);
        end
        else
        begin
            unique case (kind)
                KIND_ERR, KIND_MSG:
                begin
                    if (tn == 3'd1)
                        m[KW_FROM] = 1'b1;
                    else if (tn == 3'd3)
                        m[KW_IS] = 1'b1;
                end
                KIND_REPLY:
                begin
                    if (tn == 3'd1)
                    begin
                        m[KW_OK]  = 1'b1;
                        m[KW_NOK] = 1'b1;
                    end
                    else if (tn == 3'd2)
                    begin
                        m[KW_IS] = 1'b1;
                    end
                end
                KIND_AUTH:
                begin
                    if (tn == 3'd2)
                        m[KW_AS] = 1'b1;
                    else if (tn == 3'd4)
                        m[KW_USING] = 1'b1;
                end
                KIND_JOIN:
                begin
                    if (tn == 3'd2)
                        m[KW_AS] = 1'b1;
                end
                default:
                begin
                    m = '0;
                end
            endcase
        end
        return m;
    endfunction

endpackage

@@ design/chat_command_validator_top.sv @@
// Chat command validator.
// Input stream (s_t*): one command byte per word, s_tlast on the final byte.
// Output stream (m_t*): one word per command, issued for the final byte only;
// m_tdata[0] is 1 when the command matched an accepted form.
// Config: APB port, four length-limit registers at byte addresses 0, 4, 8, 12
// (user, display name, secret, content); pready is tied high. Write only while
// the block is idle.
// Pipeline: a byte is captured in the input register and evaluated from there;
// its result word is registered in the output register, which drives m_tvalid.
// Throughput: one byte per cycle; the per-byte step is a handful of compares
// and saturating counter updates between the input and the result register.
// Stall: while the result word waits on m_tready the next bytes still flow;
// only a further final byte waits in the input register, and s_tready drops
// until the pending result is taken.
// Reset: clears the parse state and both stages; registers return to
// 20 / 20 / 128 / 1400.
module chat_command_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tlast,   // last_byte
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] cmd_valid, [7:1] zero
);
    import ccv_pkg::*;

    // configuration registers
    logic [5:0]  max_user_reg;
    logic [5:0]  max_disp_reg;
    logic [7:0]  max_secret_reg;
    logic [10:0] max_content_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // parse state
    logic [2:0]  tn_reg, tn_next;
    logic [2:0]  kind_reg, kind_next;
    kw_mask_t    cand_reg, cand_next;
    logic [7:0]  tlen_reg, tlen_next;
    logic [10:0] clen_reg, clen_next;
    logic        tgood_reg, tgood_next;
    logic        cgood_reg, cgood_next;
    logic        incont_reg, incont_next;

    // output stage
    logic        out_valid_reg;
    logic        out_bit_reg;

    logic        fire;
    logic        cfg_wr;
    logic [7:0]  b;
    logic [2:0]  role;
    logic [7:0]  limit;
    logic [8:0]  tlen_inc;
    logic [11:0] clen_inc;
    logic        hit_found;
    logic [3:0]  hit_idx;
    logic        is_word;
    logic        result_bit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_USER:    prdata = {26'd0, max_user_reg};
            REG_DISPLAY: prdata = {26'd0, max_disp_reg};
            REG_SECRET:  prdata = {24'd0, max_secret_reg};
            REG_CONTENT: prdata = {21'd0, max_content_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_user_reg    <= 6'd20;
            max_disp_reg    <= 6'd20;
            max_secret_reg  <= 8'd128;
            max_content_reg <= 11'd1400;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_USER:    max_user_reg    <= pwdata[5:0];
                REG_DISPLAY: max_disp_reg    <= pwdata[5:0];
                REG_SECRET:  max_secret_reg  <= pwdata[7:0];
                REG_CONTENT: max_content_reg <= pwdata[10:0];
            endcase
        end
    end

    // A byte that carries no result never waits for the output register.
    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bit_reg};

    always_comb
    begin
        tn_next     = tn_reg;
        kind_next   = kind_reg;
        cand_next   = cand_reg;
        tlen_next   = tlen_reg;
        clen_next   = clen_reg;
        tgood_next  = tgood_reg;
        cgood_next  = cgood_reg;
        incont_next = incont_reg;
        hit_found   = 1'b0;
        hit_idx     = 4'd0;
        limit       = 8'd255;
        tlen_inc    = 9'd0;
        clen_inc    = 12'd0;
        result_bit  = 1'b0;

        b = in_byte_reg;
        if (b >= "a" && b <= "z")
            b = b - 8'h20;
        is_word = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || b == CH_DASH;
        role = role_of(tn_reg, kind_reg);

        if (incont_reg)
        begin
            if (in_byte_reg < CH_SPACE || in_byte_reg > CH_TILDE)
                cgood_next = 1'b0;
            // a single trailing space is not content
            if (!(in_byte_reg == CH_SPACE && in_last_reg))
            begin
                clen_inc = {1'b0, clen_reg} + 12'd1;
                if (clen_inc > {1'b0, max_content_reg})
                    cgood_next = 1'b0;
                clen_next = clen_inc[11] ? 11'h7FF : clen_inc[10:0];
            end
        end
        else if (in_byte_reg != CH_SPACE)
        begin
            unique case (role)
                ROLE_KEY:
                begin
                    for (int k = 0; k < KW_COUNT; k++)
                    begin
                        if (tlen_reg >= {5'd0, KW_LEN[k]})
                            cand_next[k] = 1'b0;
                        else if (KW_TEXT[k][tlen_reg[2:0]] != b)
                            cand_next[k] = 1'b0;
                    end
                end
                ROLE_DISP:
                begin
                    limit = {2'd0, max_disp_reg};
                    if (b < CH_BANG || b > CH_TILDE)
                        tgood_next = 1'b0;
                end
                ROLE_USER:
                begin
                    limit = {2'd0, max_user_reg};
                    if (!is_word)
                        tgood_next = 1'b0;
                end
                ROLE_SECRET:
                begin
                    limit = max_secret_reg;
                    if (!is_word)
                        tgood_next = 1'b0;
                end
                default:
                begin
                    limit = 8'd255;
                end
            endcase
            tlen_inc = {1'b0, tlen_reg} + 9'd1;
            if (tlen_inc > {1'b0, limit})
                tgood_next = 1'b0;
            tlen_next = tlen_inc[8] ? 8'hFF : tlen_inc[7:0];
        end

        // token end: a space, or the final byte outside content
        if (!incont_reg && (in_byte_reg == CH_SPACE || in_last_reg))
        begin
            if (role == ROLE_KEY)
            begin
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (cand_next[k] && {5'd0, KW_LEN[k]} == tlen_next)
                    begin
                        hit_found = 1'b1;
                        hit_idx   = 4'(k);
                    end
                end
                if (!hit_found)
                    cgood_next = 1'b0;
                else if (tn_reg == 3'd0)
                    kind_next = hit_idx[2:0] + 3'd1;
            end
            else if (role == ROLE_EXTRA)
            begin
                cgood_next = 1'b0;
            end
            else if (role != ROLE_CHAN && !tgood_next)
            begin
                cgood_next = 1'b0;
            end
            if (((kind_next == KIND_ERR || kind_next == KIND_MSG) && tn_reg == 3'd3) ||
                (kind_next == KIND_REPLY && tn_reg == 3'd2))
                incont_next = 1'b1;
            if (tn_reg != 3'd7)
                tn_next = tn_reg + 3'd1;
            cand_next  = mask_of(tn_next, kind_next);
            tlen_next  = 8'd0;
            tgood_next = 1'b1;
        end

        if (in_last_reg)
        begin
            result_bit = cgood_next;
            unique case (kind_next)
                KIND_ERR, KIND_REPLY, KIND_MSG:
                    if (!incont_reg) result_bit = 1'b0;
                KIND_AUTH:
                    if (tn_next != 3'd6) result_bit = 1'b0;
                KIND_JOIN:
                    if (tn_next != 3'd4) result_bit = 1'b0;
                KIND_BYE:
                    if (tn_next != 3'd1) result_bit = 1'b0;
                default:
                    result_bit = 1'b0;
            endcase
            // back to the state for a new command
            tn_next     = 3'd0;
            kind_next   = KIND_NONE;
            clen_next   = 11'd0;
            cgood_next  = 1'b1;
            incont_next = 1'b0;
            cand_next   = mask_of(3'd0, KIND_NONE);
            tlen_next   = 8'd0;
            tgood_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tn_reg        <= 3'd0;
            kind_reg      <= KIND_NONE;
            cand_reg      <= kw_mask_t'(12'h03F);
            tlen_reg      <= 8'd0;
            clen_reg      <= 11'd0;
            tgood_reg     <= 1'b1;
            cgood_reg     <= 1'b1;
            incont_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                tn_reg     <= tn_next;
                kind_reg   <= kind_next;
                cand_reg   <= cand_next;
                tlen_reg   <= tlen_next;
                clen_reg   <= clen_next;
                tgood_reg  <= tgood_next;
                cgood_reg  <= cgood_next;
                incont_reg <= incont_next;
            end
            if (fire && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg)
            out_bit_reg <= result_bit;
    end

endmodule
